>>> rtl/sh_next_pc_resolver_core_macros.svh
// Assertion helpers for the next-PC resolver.
`ifndef SH_NEXT_PC_RESOLVER_CORE_MACROS_SVH
`define SH_NEXT_PC_RESOLVER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset.
`define SHNPC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("shnpc assertion failed");

// Next-cycle implication, sampled on clk_i, quiet during reset.
`define SHNPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("shnpc assertion failed");

`endif

>>> rtl/shnpc_pkg.sv
package shnpc_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned InsnW = 16;

  localparam logic [3:0] OpMisc0 = 4'h0;
  localparam logic [3:0] OpMisc4 = 4'h4;
  localparam logic [3:0] OpBcond = 4'h8;
  localparam logic [3:0] OpBra   = 4'hA;
  localparam logic [3:0] OpBsr   = 4'hB;

  localparam logic [7:0] FnBsrf = 8'h03;
  localparam logic [7:0] FnBraf = 8'h23;
  localparam logic [7:0] FnJsr  = 8'h0B;
  localparam logic [7:0] FnJmp  = 8'h2B;

  localparam logic [InsnW-1:0] RtsWord = 16'h000B;

  localparam logic [3:0] CondBt  = 4'h9;
  localparam logic [3:0] CondBf  = 4'hB;
  localparam logic [3:0] CondBts = 4'hD;
  localparam logic [3:0] CondBfs = 4'hF;

  localparam logic [AddrW-1:0] WordBytes = 32'd2;

  typedef struct packed {
    logic [AddrW-1:0] pc;
    logic [InsnW-1:0] instruction;
    logic             t_flag;
    logic [AddrW-1:0] rn_value;
    logic [AddrW-1:0] pr_value;
  } item_t;

  typedef struct packed {
    logic [AddrW-1:0] next_pc;
    logic             is_call;
  } result_t;

endpackage

>>> rtl/sh_next_pc_resolver_core.sv
// Channel   Handshake            Payload
// command   start / busy         pc_i, instruction_i, t_flag_i, rn_value_i, pr_value_i
// result    done_o (one cycle)   next_pc_o, is_call_o
//
// From an accepted start to done_o: input register, decode and add,
// result register. busy stays low, so a new transfer is taken every cycle.
// rst_ni clears the valid flags of both stages; payload registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sh_next_pc_resolver_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [shnpc_pkg::AddrW-1:0] pc_i,
  input  logic [shnpc_pkg::InsnW-1:0] instruction_i,
  input  logic                        t_flag_i,
  input  logic [shnpc_pkg::AddrW-1:0] rn_value_i,
  input  logic [shnpc_pkg::AddrW-1:0] pr_value_i,
  output logic                        done_o,
  output logic [shnpc_pkg::AddrW-1:0] next_pc_o,
  output logic                        is_call_o
);

  logic               in_vld_q;
  logic               out_vld_q;
  shnpc_pkg::item_t   item_d, item_q;
  shnpc_pkg::result_t res_d, res_q;

  assign busy = 1'b0;

  assign item_d.pc          = pc_i;
  assign item_d.instruction = instruction_i;
  assign item_d.t_flag      = t_flag_i;
  assign item_d.rn_value    = rn_value_i;
  assign item_d.pr_value    = pr_value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start && !busy;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      item_q <= item_d;
    end
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  shnpc_decode u_decode (
    .item_i   (item_q),
    .result_o (res_d)
  );

  assign done_o    = out_vld_q;
  assign next_pc_o = res_q.next_pc;
  assign is_call_o = res_q.is_call;

endmodule

>>> rtl/shnpc_decode.sv
module shnpc_decode (
  input  shnpc_pkg::item_t   item_i,
  output shnpc_pkg::result_t result_o
);

  logic [3:0]                  op;
  logic [3:0]                  cond;
  logic [7:0]                  fn;
  logic [shnpc_pkg::AddrW-1:0] seq_pc;
  logic [shnpc_pkg::AddrW-1:0] base_pc;
  logic [shnpc_pkg::AddrW-1:0] disp8;
  logic [shnpc_pkg::AddrW-1:0] disp12;
  logic [shnpc_pkg::AddrW-1:0] tgt8;

  assign op      = item_i.instruction[15:12];
  assign cond    = item_i.instruction[11:8];
  assign fn      = item_i.instruction[7:0];
  assign seq_pc  = item_i.pc + shnpc_pkg::WordBytes;
  assign base_pc = item_i.pc + (shnpc_pkg::WordBytes << 1);
  assign disp8   = {{(shnpc_pkg::AddrW-9){fn[7]}}, fn, 1'b0};
  assign disp12  = {{(shnpc_pkg::AddrW-13){item_i.instruction[11]}},
                    item_i.instruction[11:0], 1'b0};
  assign tgt8    = base_pc + disp8;

  always_comb begin
    result_o.next_pc = seq_pc;
    result_o.is_call = 1'b0;
    case (op)
      shnpc_pkg::OpMisc0: begin
        if (fn == shnpc_pkg::FnBsrf || fn == shnpc_pkg::FnBraf) begin
          result_o.next_pc = base_pc + item_i.rn_value;
          result_o.is_call = (fn == shnpc_pkg::FnBsrf);
        end else if (item_i.instruction == shnpc_pkg::RtsWord) begin
          result_o.next_pc = item_i.pr_value;
        end
      end
      shnpc_pkg::OpMisc4: begin
        if (fn == shnpc_pkg::FnJsr || fn == shnpc_pkg::FnJmp) begin
          result_o.next_pc = item_i.rn_value;
          result_o.is_call = (fn == shnpc_pkg::FnJsr);
        end
      end
      shnpc_pkg::OpBcond: begin
        case (cond)
          shnpc_pkg::CondBt:  result_o.next_pc = item_i.t_flag ? tgt8 : seq_pc;
          shnpc_pkg::CondBf:  result_o.next_pc = item_i.t_flag ? seq_pc : tgt8;
          shnpc_pkg::CondBts: result_o.next_pc = item_i.t_flag ? tgt8 : base_pc;
          shnpc_pkg::CondBfs: result_o.next_pc = item_i.t_flag ? base_pc : tgt8;
          default:            result_o.next_pc = seq_pc;
        endcase
      end
      shnpc_pkg::OpBra, shnpc_pkg::OpBsr: begin
        result_o.next_pc = base_pc + disp12;
        result_o.is_call = (op == shnpc_pkg::OpBsr);
      end
      default: begin
        result_o.next_pc = seq_pc;
        result_o.is_call = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/shnpc_checker.sv
`include "sh_next_pc_resolver_core_macros.svh"

module shnpc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [shnpc_pkg::InsnW-1:0] instruction_i,
  input logic [shnpc_pkg::AddrW-1:0] pr_value_i,
  input logic                        done_o,
  input logic [shnpc_pkg::AddrW-1:0] next_pc_o,
  input logic                        is_call_o
);

  `SHNPC_ASSERT_NEXT(a_start_gives_done, start && !busy, ##1 done_o)

  `SHNPC_ASSERT_IMPL(a_done_has_start, done_o, $past(start && !busy, 2))

  `SHNPC_ASSERT_IMPL(a_call_opcode, done_o && is_call_o,
    $past(instruction_i[15:12] == shnpc_pkg::OpBsr ||
          instruction_i[15:12] == shnpc_pkg::OpMisc0 ||
          instruction_i[15:12] == shnpc_pkg::OpMisc4, 2))

  `SHNPC_ASSERT_IMPL(a_rts_to_pr,
    done_o && $past(instruction_i == shnpc_pkg::RtsWord, 2),
    next_pc_o == $past(pr_value_i, 2) && !is_call_o)

endmodule

bind sh_next_pc_resolver_core shnpc_checker u_shnpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .instruction_i (instruction_i),
  .pr_value_i    (pr_value_i),
  .done_o        (done_o),
  .next_pc_o     (next_pc_o),
  .is_call_o     (is_call_o)
);
